// ----- src/spbp_pkg.sv -----
// Shared types and codes for the slot packet buffer pool.
`timescale 1ns / 1ps

package spbp_pkg;

   localparam int OPCODE_W = 3;
   localparam int LENGTH_W = 12;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 4;
   localparam int STEPS_W  = 4;

   // Bytes of every slot kept back for the flag and the length.
   localparam int RSVD_BYTES = 5;

   localparam logic [OPCODE_W-1:0] OP_ADD_START = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD_BYTE  = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_GET_NEXT  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_READ_BYTE = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_RELEASE   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NO_SEL   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd5;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [LENGTH_W-1:0] length;
      logic [BYTE_W-1:0]   data_byte;
      logic [BYTE_W-1:0]   offset;
   } spbp_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [STEPS_W-1:0]  scan_steps;
      logic [BYTE_W-1:0]   length_out;
      logic [BYTE_W-1:0]   data_out;
   } spbp_rsp_type;

   typedef struct packed {
      logic exec;
      logic finish;
   } spbp_cmd_type;

endpackage

// ----- src/spbp_scan.sv -----
// Rotating priority search for the first flagged slot after a pointer.
`timescale 1ns / 1ps

module spbp_scan
   import spbp_pkg::*;
#(
   parameter int SLOT_COUNT = 16,
   parameter int IDX_W      = 4
) (
   input  logic [IDX_W-1:0]      ptr,
   input  logic [SLOT_COUNT-1:0] flags,
   output logic                  hit,
   output logic [IDX_W-1:0]      slot,
   output logic [IDX_W-1:0]      steps
);

   always_comb begin
      logic [IDX_W:0] cand;
      hit   = 1'b0;
      slot  = '0;
      steps = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         cand = {1'b0, ptr} + (IDX_W+1)'(i + 1);
         if (cand >= (IDX_W+1)'(SLOT_COUNT)) begin
            cand = cand - (IDX_W+1)'(SLOT_COUNT);
         end
         if (!hit && flags[cand[IDX_W-1:0]]) begin
            hit   = 1'b1;
            slot  = cand[IDX_W-1:0];
            steps = IDX_W'(i);
         end
      end
   end

endmodule

// ----- src/spbp_ctrl.sv -----
// Controller: accept, respond and output handshake sequencing.
`timescale 1ns / 1ps

module spbp_ctrl
   import spbp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output spbp_cmd_type cmd
);

   localparam logic [0:0] S_IDLE = 1'b0;
   localparam logic [0:0] S_RESP = 1'b1;

   logic [0:0] state_ff;
   logic [0:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd.exec   = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/spbp_datapath.sv -----
// Datapath: slot flags, pointers, fill state, length and payload memories.
`timescale 1ns / 1ps

module spbp_datapath
   import spbp_pkg::*;
#(
   parameter int SLOT_COUNT = 16,
   parameter int SLOT_BYTES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  spbp_cmd_type cmd,
   input  spbp_req_type req_data,
   output spbp_rsp_type rsp_data
);

   localparam int IDX_W     = $clog2(SLOT_COUNT);
   localparam int SLOT_CAP  = SLOT_BYTES - RSVD_BYTES;
   localparam int LEN_CAP   = (SLOT_CAP < (1 << LENGTH_W)) ? SLOT_CAP : (1 << LENGTH_W);
   localparam int OFF_W     = (LEN_CAP > 1) ? $clog2(LEN_CAP) : 1;
   localparam int ADDR_W    = IDX_W + OFF_W;
   localparam int PAY_DEPTH = SLOT_COUNT << OFF_W;

   logic [SLOT_COUNT-1:0] occupied_ff, occupied_in;
   logic [IDX_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic                  sel_ff, sel_in;
   logic                  fill_ff, fill_in;
   logic [LENGTH_W-1:0]   fill_off_ff, fill_off_in;
   logic [LENGTH_W-1:0]   fill_len_ff, fill_len_in;
   logic [LENGTH_W-1:0]   sel_len_ff;
   logic                  use_len_ff, use_len_in;
   logic                  use_data_ff, use_data_in;
   spbp_rsp_type          res_ff, res_in;
   spbp_rsp_type          rsp_ff, rsp_in;

   logic [LENGTH_W-1:0] len_mem [SLOT_COUNT];
   logic [LENGTH_W-1:0] len_rd_ff;
   logic [BYTE_W-1:0]   pay_mem [PAY_DEPTH];
   logic [BYTE_W-1:0]   pay_rd_ff;

   logic                  len_we;
   logic                  pay_we;
   logic [ADDR_W-1:0]     pay_waddr;
   logic [ADDR_W-1:0]     pay_raddr;
   logic                  is_add;
   logic                  too_long;
   logic [LENGTH_W-1:0]   fill_next;
   logic [IDX_W-1:0]      scan_ptr;
   logic [SLOT_COUNT-1:0] scan_flags;
   logic                  scan_hit;
   logic [IDX_W-1:0]      scan_slot;
   logic [IDX_W-1:0]      scan_steps;

   assign is_add     = (req_data.opcode == OP_ADD_START);
   assign scan_ptr   = is_add ? wr_ptr_ff : rd_ptr_ff;
   assign scan_flags = is_add ? ~occupied_ff : occupied_ff;
   assign too_long   = 32'(req_data.length) > 32'(SLOT_CAP);
   assign fill_next  = fill_off_ff + LENGTH_W'(1);
   assign pay_waddr  = {wr_ptr_ff, fill_off_ff[OFF_W-1:0]};
   assign pay_raddr  = {rd_ptr_ff, OFF_W'(req_data.offset)};

   spbp_scan #(
      .SLOT_COUNT(SLOT_COUNT),
      .IDX_W     (IDX_W)
   ) u_scan (
      .ptr  (scan_ptr),
      .flags(scan_flags),
      .hit  (scan_hit),
      .slot (scan_slot),
      .steps(scan_steps)
   );

   always_comb begin
      occupied_in = occupied_ff;
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      sel_in      = sel_ff;
      fill_in     = fill_ff;
      fill_off_in = fill_off_ff;
      fill_len_in = fill_len_ff;
      use_len_in  = 1'b0;
      use_data_in = 1'b0;
      len_we      = 1'b0;
      pay_we      = 1'b0;
      res_in      = '0;
      unique case (req_data.opcode)
         OP_ADD_START: begin
            if (too_long) begin
               res_in.status = ST_TOO_LONG;
            end else begin
               fill_in = 1'b0;
               if (scan_hit) begin
                  wr_ptr_in = scan_slot;
                  len_we    = 1'b1;
                  if (req_data.length == '0) begin
                     occupied_in[scan_slot] = 1'b1;
                  end else begin
                     fill_in     = 1'b1;
                     fill_len_in = req_data.length;
                     fill_off_in = '0;
                  end
                  res_in.status     = ST_OK;
                  res_in.slot       = SLOT_W'(scan_slot);
                  res_in.scan_steps = STEPS_W'(scan_steps);
                  res_in.length_out = BYTE_W'(req_data.length);
               end else begin
                  res_in.status = ST_FULL;
               end
            end
         end
         OP_ADD_BYTE: begin
            if (!fill_ff) begin
               res_in.status = ST_NO_SEL;
            end else begin
               pay_we      = 1'b1;
               fill_off_in = fill_next;
               if (fill_next == fill_len_ff) begin
                  occupied_in[wr_ptr_ff] = 1'b1;
                  fill_in                = 1'b0;
               end
               res_in.status     = ST_OK;
               res_in.slot       = SLOT_W'(wr_ptr_ff);
               res_in.length_out = BYTE_W'(fill_len_ff);
            end
         end
         OP_GET_NEXT: begin
            if (scan_hit) begin
               rd_ptr_in         = scan_slot;
               sel_in            = 1'b1;
               use_len_in        = 1'b1;
               res_in.status     = ST_OK;
               res_in.slot       = SLOT_W'(scan_slot);
               res_in.scan_steps = STEPS_W'(scan_steps);
            end else begin
               sel_in        = 1'b0;
               res_in.status = ST_EMPTY;
            end
         end
         OP_READ_BYTE: begin
            if (!sel_ff) begin
               res_in.status = ST_NO_SEL;
            end else begin
               res_in.slot       = SLOT_W'(rd_ptr_ff);
               res_in.length_out = BYTE_W'(sel_len_ff);
               if (LENGTH_W'(req_data.offset) >= sel_len_ff) begin
                  res_in.status = ST_RANGE;
               end else begin
                  res_in.status = ST_OK;
                  use_data_in   = 1'b1;
               end
            end
         end
         OP_RELEASE: begin
            if (!sel_ff) begin
               res_in.status = ST_NO_SEL;
            end else begin
               occupied_in[rd_ptr_ff] = 1'b0;
               sel_in                 = 1'b0;
               res_in.status          = ST_OK;
               res_in.slot            = SLOT_W'(rd_ptr_ff);
            end
         end
         default: begin
            res_in = '0;
         end
      endcase
   end

   always_comb begin
      rsp_in = res_ff;
      if (use_len_ff) begin
         rsp_in.length_out = BYTE_W'(len_rd_ff);
      end
      if (use_data_ff) begin
         rsp_in.data_out = pay_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff <= '0;
         wr_ptr_ff   <= IDX_W'(SLOT_COUNT - 1);
         rd_ptr_ff   <= IDX_W'(SLOT_COUNT - 1);
         sel_ff      <= 1'b0;
         fill_ff     <= 1'b0;
         fill_off_ff <= '0;
      end else if (cmd.exec) begin
         occupied_ff <= occupied_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         sel_ff      <= sel_in;
         fill_ff     <= fill_in;
         fill_off_ff <= fill_off_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         fill_len_ff <= fill_len_in;
         res_ff      <= res_in;
         use_len_ff  <= use_len_in;
         use_data_ff <= use_data_in;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
         if (use_len_ff) begin
            sel_len_ff <= len_rd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (len_we) begin
            len_mem[scan_slot] <= req_data.length;
         end
         len_rd_ff <= len_mem[scan_slot];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (pay_we) begin
            pay_mem[pay_waddr] <= req_data.data_byte;
         end
         pay_rd_ff <= pay_mem[pay_raddr];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- src/slot_packet_buffer_pool_top.sv -----
// Top level of the slot packet buffer pool.
// A pool of SLOT_COUNT fixed-size slots holding packets of up to SLOT_BYTES-5 bytes.
// Every request beat returns exactly one response beat. An item is handled in order:
// in the accept cycle the rotating slot search runs and the length and payload
// memories are addressed; in the response state their registered read data joins the
// response, which lands in the output register. The input is held off in the response
// state, which lasts for as long as a finished response cannot enter the output
// register. Slot flags clear at reset; payload and lengths need no clearing.
`timescale 1ns / 1ps

module slot_packet_buffer_pool_top
   import spbp_pkg::*;
#(
   parameter int SLOT_COUNT = 16,
   parameter int SLOT_BYTES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  spbp_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output spbp_rsp_type rsp_data
);

   spbp_cmd_type cmd;

   spbp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd)
   );

   spbp_datapath #(
      .SLOT_COUNT(SLOT_COUNT),
      .SLOT_BYTES(SLOT_BYTES)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .req_data(req_data),
      .rsp_data(rsp_data)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted without entering the response cycle");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= ST_RANGE))
      else $error("response status out of range");

   a_steps_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.scan_steps != '0)) |-> (rsp_data.status == ST_OK))
      else $error("scan distance reported on a failed beat");

   a_data_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.data_out != '0)) |-> (rsp_data.status == ST_OK))
      else $error("payload byte reported on a failed beat");
`endif

endmodule
